// ===== src/alte_pkg.sv =====
package alte_pkg;

   // field widths of the request and response words
   localparam int MODE_W = 3;
   localparam int POS_W  = 7;
   localparam int DATA_W = 32;
   localparam int STAT_W = 3;
   localparam int IDX_W  = 6;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK     = 3'd0;
   localparam logic [STAT_W-1:0] STAT_FULL   = 3'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY  = 3'd2;
   localparam logic [STAT_W-1:0] STAT_BADPOS = 3'd3;
   localparam logic [STAT_W-1:0] STAT_MISS   = 3'd4;

   // walk sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_INSERT,
      S_DELETE,
      S_SEARCH
   } state_type;

endpackage

// ===== src/alte_ram.sv =====
module alte_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [AW-1:0]                     wr_addr,
   input  logic signed [alte_pkg::DATA_W-1:0] wr_data,
   input  logic [AW-1:0]                     rd_addr,
   output logic signed [alte_pkg::DATA_W-1:0] rd_data
);

   logic signed [alte_pkg::DATA_W-1:0] mem [DEPTH];
   logic signed [alte_pkg::DATA_W-1:0] rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/array_list_table_engine.sv =====
// Ordered table of signed 32-bit words held in one single-port-write, registered-read
// memory. Append and every request that ends in an error status are handled in the
// cycle the request is taken: busy stays low and the response strobe follows in the
// next cycle, so such requests can issue back to back. Read all, search, insert and
// delete walk the memory one entry per cycle, limited by the one read port, busy being
// high throughout: read all gives one response word per cycle once the first read
// returns, search ends at the first match or the last entry, and insert at a position
// equal to the fill has no entries to move. The receiver cannot
// stall: each response word is on the rsp_ ports for exactly one cycle, marked by
// rsp_strobe, with rsp_last on the final word of a request. The memory is never
// cleared; only read data from entries below the fill count is ever used.
module array_list_table_engine #(
   parameter int DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [alte_pkg::MODE_W-1:0]        req_mode,
   input  logic [alte_pkg::POS_W-1:0]         req_position,
   input  logic signed [alte_pkg::DATA_W-1:0] req_value,
   output logic                               rsp_strobe,
   output logic [alte_pkg::STAT_W-1:0]        rsp_status,
   output logic signed [alte_pkg::DATA_W-1:0] rsp_data,
   output logic [alte_pkg::IDX_W-1:0]         rsp_index,
   output logic                               rsp_last
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
   localparam logic [CW-1:0] ONE      = CW'(1);

   alte_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                     fill_ff, fill_in;
   logic [CW-1:0]                     ptr_ff, ptr_in;
   logic [CW-1:0]                     op_pos_ff, op_pos_in;
   logic signed [alte_pkg::DATA_W-1:0] op_val_ff, op_val_in;
   logic signed [alte_pkg::DATA_W-1:0] rem_ff, rem_in;
   logic                              pend_ff, pend_in;
   logic [AW-1:0]                     pend_idx_ff, pend_idx_in;

   logic                              rsp_strobe_ff, rsp_strobe_in;
   logic [alte_pkg::STAT_W-1:0]       rsp_status_ff, rsp_status_in;
   logic signed [alte_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [alte_pkg::IDX_W-1:0]        rsp_index_ff, rsp_index_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic                              ram_we;
   logic [AW-1:0]                     ram_waddr;
   logic signed [alte_pkg::DATA_W-1:0] ram_wdata;
   logic [AW-1:0]                     ram_raddr;
   logic signed [alte_pkg::DATA_W-1:0] ram_rdata;

   logic                              accept;
   logic                              is_full;
   logic                              is_empty;
   logic [alte_pkg::POS_W-1:0]        fill_pos;
   logic                              last_hit;
   logic                              match;

   alte_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // shared condition flags
   assign busy     = (state_ff != alte_pkg::S_IDLE);
   assign accept   = start && !busy;
   assign is_full  = (fill_ff == FULL_CNT);
   assign is_empty = (fill_ff == '0);
   assign fill_pos = alte_pkg::POS_W'(fill_ff);
   assign last_hit = ((CW'(pend_idx_ff) + ONE) == fill_ff);
   assign match    = (ram_rdata == op_val_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         alte_pkg::S_IDLE: begin
            if (accept) begin
               case (req_mode)
                  alte_pkg::MODE_READ: begin
                     if (!is_empty) state_in = alte_pkg::S_READ;
                  end
                  alte_pkg::MODE_INSERT: begin
                     if (!is_full && req_position <= fill_pos) state_in = alte_pkg::S_INSERT;
                  end
                  alte_pkg::MODE_DELETE: begin
                     if (!is_empty && req_position < fill_pos) state_in = alte_pkg::S_DELETE;
                  end
                  alte_pkg::MODE_SEARCH: begin
                     if (!is_empty) state_in = alte_pkg::S_SEARCH;
                  end
                  default: state_in = alte_pkg::S_IDLE;
               endcase
            end
         end
         alte_pkg::S_READ: begin
            if (pend_ff && last_hit) state_in = alte_pkg::S_IDLE;
         end
         alte_pkg::S_SEARCH: begin
            if (pend_ff && (match || last_hit)) state_in = alte_pkg::S_IDLE;
         end
         alte_pkg::S_INSERT: begin
            if (ptr_ff == op_pos_ff && !pend_ff) state_in = alte_pkg::S_IDLE;
         end
         alte_pkg::S_DELETE: begin
            if (ptr_ff == fill_ff && !pend_ff) state_in = alte_pkg::S_IDLE;
         end
      endcase
   end

   // datapath, memory access and response
   always_comb begin
      fill_in       = fill_ff;
      ptr_in        = ptr_ff;
      op_pos_in     = op_pos_ff;
      op_val_in     = op_val_ff;
      rem_in        = rem_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = req_value;
      ram_raddr     = '0;
      rsp_strobe_in = 1'b0;
      rsp_status_in = alte_pkg::STAT_OK;
      rsp_data_in   = '0;
      rsp_index_in  = '0;
      rsp_last_in   = 1'b1;

      unique case (state_ff)
         alte_pkg::S_IDLE: begin
            if (accept) begin
               rsp_strobe_in = 1'b1;
               op_val_in     = req_value;
               op_pos_in     = CW'(req_position);
               case (req_mode)
                  alte_pkg::MODE_APPEND: begin
                     if (is_full) begin
                        rsp_status_in = alte_pkg::STAT_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(fill_ff);
                        fill_in   = fill_ff + ONE;
                     end
                  end
                  alte_pkg::MODE_READ: begin
                     ptr_in = '0;
                     if (is_empty) rsp_status_in = alte_pkg::STAT_EMPTY;
                     else rsp_strobe_in = 1'b0;
                  end
                  alte_pkg::MODE_INSERT: begin
                     ptr_in = fill_ff;
                     priority if (is_full) rsp_status_in = alte_pkg::STAT_FULL;
                     else if (req_position > fill_pos) rsp_status_in = alte_pkg::STAT_BADPOS;
                     else rsp_strobe_in = 1'b0;
                  end
                  alte_pkg::MODE_DELETE: begin
                     ptr_in = CW'(req_position);
                     priority if (is_empty) rsp_status_in = alte_pkg::STAT_EMPTY;
                     else if (req_position >= fill_pos) rsp_status_in = alte_pkg::STAT_BADPOS;
                     else rsp_strobe_in = 1'b0;
                  end
                  alte_pkg::MODE_SEARCH: begin
                     ptr_in = '0;
                     if (is_empty) rsp_status_in = alte_pkg::STAT_EMPTY;
                     else rsp_strobe_in = 1'b0;
                  end
                  default: rsp_status_in = alte_pkg::STAT_BADPOS;
               endcase
            end
         end

         // stream entries out in order
         alte_pkg::S_READ: begin
            if (ptr_ff < fill_ff) begin
               ram_raddr   = AW'(ptr_ff);
               pend_in     = 1'b1;
               pend_idx_in = AW'(ptr_ff);
               ptr_in      = ptr_ff + ONE;
            end
            if (pend_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in   = ram_rdata;
               rsp_index_in  = alte_pkg::IDX_W'(pend_idx_ff);
               rsp_last_in   = last_hit;
               if (last_hit) pend_in = 1'b0;
            end
         end

         // first match wins
         alte_pkg::S_SEARCH: begin
            if (ptr_ff < fill_ff) begin
               ram_raddr   = AW'(ptr_ff);
               pend_in     = 1'b1;
               pend_idx_in = AW'(ptr_ff);
               ptr_in      = ptr_ff + ONE;
            end
            if (pend_ff) begin
               if (match) begin
                  rsp_strobe_in = 1'b1;
                  rsp_index_in  = alte_pkg::IDX_W'(pend_idx_ff);
                  pend_in       = 1'b0;
               end else if (last_hit) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = alte_pkg::STAT_MISS;
                  pend_in       = 1'b0;
               end
            end
         end

         // move entries up from the top, each write using the read issued before it
         alte_pkg::S_INSERT: begin
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = pend_idx_ff;
               ram_wdata = ram_rdata;
            end
            if (ptr_ff > op_pos_ff) begin
               ram_raddr   = AW'(ptr_ff - ONE);
               pend_in     = 1'b1;
               pend_idx_in = AW'(ptr_ff);
               ptr_in      = ptr_ff - ONE;
            end else if (!pend_ff) begin
               ram_we        = 1'b1;
               ram_waddr     = AW'(op_pos_ff);
               ram_wdata     = op_val_ff;
               fill_in       = fill_ff + ONE;
               rsp_strobe_in = 1'b1;
            end
         end

         // capture the removed word, then move later entries down
         alte_pkg::S_DELETE: begin
            if (pend_ff) begin
               if (CW'(pend_idx_ff) == op_pos_ff) begin
                  rem_in = ram_rdata;
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = pend_idx_ff - AW'(1);
                  ram_wdata = ram_rdata;
               end
            end
            if (ptr_ff < fill_ff) begin
               ram_raddr   = AW'(ptr_ff);
               pend_in     = 1'b1;
               pend_idx_in = AW'(ptr_ff);
               ptr_in      = ptr_ff + ONE;
            end else if (!pend_ff) begin
               fill_in       = fill_ff - ONE;
               rsp_strobe_in = 1'b1;
               rsp_data_in   = rem_ff;
               rsp_index_in  = alte_pkg::IDX_W'(op_pos_ff);
            end
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= alte_pkg::S_IDLE;
         fill_ff       <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      op_pos_ff     <= op_pos_in;
      op_val_ff     <= op_val_in;
      rem_ff        <= rem_in;
      pend_idx_ff   <= pend_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_last   = rsp_last_ff;

   // fill count never passes the capacity
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_CNT)
      else $error("fill count above capacity");

   // no read stays in flight once the sequencer is idle
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == alte_pkg::S_IDLE) |-> !pend_ff)
      else $error("pending read while idle");

   // fill count moves by at most one per cycle
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (fill_ff == $past(fill_ff) || fill_ff == $past(fill_ff) + ONE
                         || fill_ff == $past(fill_ff) - ONE))
      else $error("fill count jumped");

   // an append is answered with a single final word in the next cycle
   a_append_resp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == alte_pkg::MODE_APPEND) |=> (rsp_strobe && rsp_last && !busy))
      else $error("append response missing");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int TBL_DEPTH = 64;

   // one request word as queued for the driver
   typedef struct {
      logic [alte_pkg::MODE_W-1:0]        mode;
      logic [alte_pkg::POS_W-1:0]         pos;
      logic signed [alte_pkg::DATA_W-1:0] value;
      int                                 gap;
      bit                                 drain;
   } req_word_type;

   // one response word as predicted
   typedef struct {
      logic [alte_pkg::STAT_W-1:0]        status;
      logic signed [alte_pkg::DATA_W-1:0] data;
      logic [alte_pkg::IDX_W-1:0]         index;
      logic                               last;
   } rsp_word_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               start = 1'b0;
   logic                               busy;
   logic [alte_pkg::MODE_W-1:0]        req_mode = '0;
   logic [alte_pkg::POS_W-1:0]         req_position = '0;
   logic signed [alte_pkg::DATA_W-1:0] req_value = '0;
   logic                               rsp_strobe;
   logic [alte_pkg::STAT_W-1:0]        rsp_status;
   logic signed [alte_pkg::DATA_W-1:0] rsp_data;
   logic [alte_pkg::IDX_W-1:0]         rsp_index;
   logic                               rsp_last;

   array_list_table_engine #(
      .DEPTH(TBL_DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_mode    (req_mode),
      .req_position(req_position),
      .req_value   (req_value),
      .rsp_strobe  (rsp_strobe),
      .rsp_status  (rsp_status),
      .rsp_data    (rsp_data),
      .rsp_index   (rsp_index),
      .rsp_last    (rsp_last)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("[array_list_table_engine] ERROR");
      $finish;
   end

   req_word_type pend_q[$];
   rsp_word_type rsp_expected[$];

   // shadow of the table contents and fill count
   logic signed [alte_pkg::DATA_W-1:0] tbl_entries [TBL_DEPTH];
   int tbl_fill = 0;

   int err_cnt = 0;
   int taken_cnt = 0;
   int sent_cnt = 0;
   int idle_cnt = 0;
   int rsp_checked = 0;
   int full_reads = 0;
   int stat_cnt [8];

   // generator state
   int gen_fill = 0;
   int gap_max = 8;
   bit drain_next = 1'b0;
   logic signed [alte_pkg::DATA_W-1:0] val_pool [8];

   function automatic void push_rsp(input logic [alte_pkg::STAT_W-1:0] status,
                                    input logic signed [alte_pkg::DATA_W-1:0] data,
                                    input int idx, input bit last);
      rsp_word_type w;
      w.status = status;
      w.data   = data;
      w.index  = alte_pkg::IDX_W'(idx);
      w.last   = last;
      rsp_expected.push_back(w);
      stat_cnt[int'(status)]++;
   endfunction

   // apply one accepted request word to the shadow table and predict its responses
   task automatic apply_request(input logic [alte_pkg::MODE_W-1:0] mode,
                                input logic [alte_pkg::POS_W-1:0] pos,
                                input logic signed [alte_pkg::DATA_W-1:0] val);
      int i;
      int p;
      int hit_at;
      logic signed [alte_pkg::DATA_W-1:0] removed;
      p = int'(pos);
      hit_at = -1;
      case (mode)
         alte_pkg::MODE_APPEND: begin
            if (tbl_fill >= TBL_DEPTH) begin
               push_rsp(alte_pkg::STAT_FULL, 0, 0, 1'b1);
            end else begin
               tbl_entries[tbl_fill] = val;
               tbl_fill++;
               push_rsp(alte_pkg::STAT_OK, 0, 0, 1'b1);
            end
         end
         alte_pkg::MODE_READ: begin
            if (tbl_fill == 0) begin
               push_rsp(alte_pkg::STAT_EMPTY, 0, 0, 1'b1);
            end else begin
               if (tbl_fill == TBL_DEPTH) full_reads++;
               for (i = 0; i < tbl_fill; i++)
                  push_rsp(alte_pkg::STAT_OK, tbl_entries[i], i, i == tbl_fill - 1);
            end
         end
         alte_pkg::MODE_INSERT: begin
            // full is checked before the position
            if (tbl_fill >= TBL_DEPTH) begin
               push_rsp(alte_pkg::STAT_FULL, 0, 0, 1'b1);
            end else if (p > tbl_fill) begin
               push_rsp(alte_pkg::STAT_BADPOS, 0, 0, 1'b1);
            end else begin
               for (i = tbl_fill; i > p; i--)
                  tbl_entries[i] = tbl_entries[i-1];
               tbl_entries[p] = val;
               tbl_fill++;
               push_rsp(alte_pkg::STAT_OK, 0, 0, 1'b1);
            end
         end
         alte_pkg::MODE_DELETE: begin
            if (tbl_fill == 0) begin
               push_rsp(alte_pkg::STAT_EMPTY, 0, 0, 1'b1);
            end else if (p >= tbl_fill) begin
               push_rsp(alte_pkg::STAT_BADPOS, 0, 0, 1'b1);
            end else begin
               removed = tbl_entries[p];
               for (i = p; i + 1 < tbl_fill; i++)
                  tbl_entries[i] = tbl_entries[i+1];
               tbl_fill--;
               push_rsp(alte_pkg::STAT_OK, removed, p, 1'b1);
            end
         end
         alte_pkg::MODE_SEARCH: begin
            if (tbl_fill == 0) begin
               push_rsp(alte_pkg::STAT_EMPTY, 0, 0, 1'b1);
            end else begin
               // first match wins
               for (i = 0; i < tbl_fill && hit_at < 0; i++)
                  if (tbl_entries[i] == val) hit_at = i;
               if (hit_at >= 0) push_rsp(alte_pkg::STAT_OK, 0, hit_at, 1'b1);
               else push_rsp(alte_pkg::STAT_MISS, 0, 0, 1'b1);
            end
         end
         default: begin
            // unknown mode leaves the table alone
            push_rsp(alte_pkg::STAT_BADPOS, 0, 0, 1'b1);
         end
      endcase
   endtask

   // monitor: check response words, then record an accepted request word
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset) begin
         if (rsp_strobe) begin
            if (rsp_expected.size() == 0) begin
               $error("unexpected response word: status %0d data %0d index %0d last %0b",
                      rsp_status, rsp_data, rsp_index, rsp_last);
               err_cnt++;
            end else begin
               e = rsp_expected.pop_front();
               rsp_checked++;
               if (rsp_status !== e.status) begin
                  $error("status: expected %0d, actual %0d", e.status, rsp_status);
                  err_cnt++;
               end
               if (rsp_data !== e.data) begin
                  $error("data: expected %0d, actual %0d", e.data, rsp_data);
                  err_cnt++;
               end
               if (rsp_index !== e.index) begin
                  $error("index: expected %0d, actual %0d", e.index, rsp_index);
                  err_cnt++;
               end
               if (rsp_last !== e.last) begin
                  $error("last: expected %0b, actual %0b", e.last, rsp_last);
                  err_cnt++;
               end
            end
         end
         if (start && !busy) begin
            apply_request(req_mode, req_position, req_value);
            taken_cnt++;
         end
      end
   end

   // driver: present queued request words at the falling edge
   always @(negedge clock) begin
      req_word_type cur;
      bit hold;
      bit issue;
      hold  = 1'b0;
      issue = 1'b0;
      if (!reset) begin
         if (start && taken_cnt != sent_cnt) begin
            hold = 1'b1;
         end else if (pend_q.size() != 0) begin
            if (idle_cnt < pend_q[0].gap) begin
               idle_cnt++;
            end else if (!(pend_q[0].drain && rsp_expected.size() != 0)) begin
               cur = pend_q.pop_front();
               issue = 1'b1;
               idle_cnt = 0;
               sent_cnt++;
            end
         end
      end
      if (issue) begin
         req_mode     <= cur.mode;
         req_position <= cur.pos;
         req_value    <= cur.value;
      end else if (!hold) begin
         // junk on the fields while start is low
         req_mode     <= alte_pkg::MODE_W'($urandom);
         req_position <= alte_pkg::POS_W'($urandom);
         req_value    <= $urandom;
      end
      start <= issue || hold;
   end

   // queue one request word and track the fill it leaves behind
   task automatic queue_req(input logic [alte_pkg::MODE_W-1:0] mode, input int pos,
                            input logic signed [alte_pkg::DATA_W-1:0] value);
      req_word_type w;
      w.mode  = mode;
      w.pos   = alte_pkg::POS_W'(pos);
      w.value = value;
      w.gap   = $urandom_range(0, gap_max);
      w.drain = drain_next;
      drain_next = 1'b0;
      pend_q.push_back(w);
      case (mode)
         alte_pkg::MODE_APPEND: if (gen_fill < TBL_DEPTH) gen_fill++;
         alte_pkg::MODE_INSERT: if (gen_fill < TBL_DEPTH && pos <= gen_fill) gen_fill++;
         alte_pkg::MODE_DELETE: if (gen_fill > 0 && pos < gen_fill) gen_fill--;
         default: ;
      endcase
   endtask

   // values drawn from a small pool so that searches hit often
   function automatic logic signed [alte_pkg::DATA_W-1:0] pick_value();
      if ($urandom_range(0, 9) < 6) return val_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   task automatic rand_req();
      int r;
      int pos;
      r = $urandom_range(0, 99);
      pos = $urandom_range(0, 127);
      if (r < 30) begin
         queue_req(alte_pkg::MODE_APPEND, pos, pick_value());
      end else if (r < 55) begin
         if ($urandom_range(0, 9) < 8) pos = $urandom_range(0, gen_fill);
         queue_req(alte_pkg::MODE_INSERT, pos, pick_value());
      end else if (r < 75) begin
         if (gen_fill > 0 && $urandom_range(0, 9) < 8) pos = $urandom_range(0, gen_fill - 1);
         queue_req(alte_pkg::MODE_DELETE, pos, pick_value());
      end else if (r < 90) begin
         queue_req(alte_pkg::MODE_SEARCH, pos, pick_value());
      end else if (r < 97) begin
         queue_req(alte_pkg::MODE_READ, pos, pick_value());
      end else begin
         queue_req(alte_pkg::MODE_W'(alte_pkg::MODE_SEARCH + 1 + $urandom_range(0, 2)),
                   pos, pick_value());
      end
   endtask

   // stimulus and end of run
   initial begin
      val_pool[0] = 32'sh7fffffff;
      val_pool[1] = 32'sh80000000;
      val_pool[2] = '0;
      val_pool[3] = -1;
      for (int k = 4; k < 8; k++) val_pool[k] = $urandom;

      // directed: empty table, extremes, first match, bad positions, unknown modes
      queue_req(alte_pkg::MODE_READ, 0, 0);
      queue_req(alte_pkg::MODE_DELETE, 0, 0);
      queue_req(alte_pkg::MODE_SEARCH, 0, 5);
      queue_req(alte_pkg::MODE_INSERT, 1, 7);
      queue_req(alte_pkg::MODE_INSERT, 0, 32'sh7fffffff);
      queue_req(alte_pkg::MODE_APPEND, 64, 32'sh80000000);
      queue_req(alte_pkg::MODE_APPEND, 127, 0);
      queue_req(alte_pkg::MODE_APPEND, 0, -1);
      queue_req(alte_pkg::MODE_INSERT, 4, 32'sh5a5a5a5a);
      queue_req(alte_pkg::MODE_INSERT, 0, 1);
      queue_req(alte_pkg::MODE_APPEND, 0, 1);
      queue_req(alte_pkg::MODE_SEARCH, 0, -1);
      queue_req(alte_pkg::MODE_SEARCH, 0, 1);
      queue_req(alte_pkg::MODE_SEARCH, 0, 12345);
      queue_req(alte_pkg::MODE_DELETE, 7, 0);
      queue_req(alte_pkg::MODE_DELETE, 64, 0);
      queue_req(alte_pkg::MODE_DELETE, 127, 0);
      queue_req(alte_pkg::MODE_DELETE, 6, 0);
      queue_req(alte_pkg::MODE_DELETE, 0, 0);
      queue_req(alte_pkg::MODE_READ, 0, 0);
      for (int m = alte_pkg::MODE_SEARCH + 1; m < 8; m++)
         queue_req(alte_pkg::MODE_W'(m), 0, 0);

      // random mix: a back-to-back stretch after a full drain, then idling
      drain_next = 1'b1;
      gap_max = 0;
      for (int k = 0; k < 35; k++) begin
         if (k == 15) gap_max = 8;
         rand_req();
      end

      // grow to full with random appends and inserts
      while (gen_fill < TBL_DEPTH) begin
         if ($urandom_range(0, 1)) queue_req(alte_pkg::MODE_APPEND, 0, pick_value());
         else queue_req(alte_pkg::MODE_INSERT, $urandom_range(0, gen_fill), pick_value());
      end

      // full table corner cases
      drain_next = 1'b1;
      queue_req(alte_pkg::MODE_APPEND, 0, 3);
      queue_req(alte_pkg::MODE_INSERT, 0, 3);
      queue_req(alte_pkg::MODE_INSERT, 127, 3);
      queue_req(alte_pkg::MODE_READ, 0, 0);
      queue_req(alte_pkg::MODE_SEARCH, 0, val_pool[$urandom_range(0, 7)]);
      queue_req(alte_pkg::MODE_DELETE, TBL_DEPTH - 1, 0);
      queue_req(alte_pkg::MODE_DELETE, 0, 0);
      queue_req(alte_pkg::MODE_INSERT, TBL_DEPTH, 9);
      queue_req(alte_pkg::MODE_INSERT, gen_fill, 9);
      queue_req(alte_pkg::MODE_INSERT, 0, 10);
      queue_req(alte_pkg::MODE_READ, 0, 0);

      // random tail
      for (int k = 0; k < 20; k++) rand_req();
      queue_req(alte_pkg::MODE_READ, 0, 0);

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      while (pend_q.size() != 0 || start || rsp_expected.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("covered %0d requests, %0d response words, %0d reads of a full table",
               taken_cnt, rsp_checked, full_reads);
      $display("status mix: ok %0d full %0d empty %0d badpos %0d miss %0d",
               stat_cnt[alte_pkg::STAT_OK], stat_cnt[alte_pkg::STAT_FULL],
               stat_cnt[alte_pkg::STAT_EMPTY], stat_cnt[alte_pkg::STAT_BADPOS],
               stat_cnt[alte_pkg::STAT_MISS]);
      if (err_cnt == 0) begin
         $display("[array_list_table_engine] OK");
      end else begin
         $display("[array_list_table_engine] ERROR");
      end
      $finish;
   end

endmodule

// ===== array_list_table_engine.f =====
src/alte_pkg.sv
src/alte_ram.sv
src/array_list_table_engine.sv
tb/tb_top.sv
